### rtl/u16u8_pkg.sv
// Package for the UTF-16 to UTF-8 transcoder: payload structs, the queue entry
// type, surrogate range constants and the UTF-8 byte encoder function.
// No dependencies.
`default_nettype none

package u16u8_pkg;

  // Surrogate ranges and fixed code points.
  localparam logic [15:0] HI_MIN      = 16'hD800;
  localparam logic [15:0] HI_MAX      = 16'hDBFF;
  localparam logic [15:0] LO_MIN      = 16'hDC00;
  localparam logic [15:0] LO_MAX      = 16'hDFFF;
  localparam logic [15:0] REPLACEMENT = 16'hFFFD;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  // Default depth of the job queue between front and back.
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Configuration register indexes (register i at byte address 4*i).
  localparam logic REG_ALLOW_LONE = 1'b0;

  // Input transaction payload.
  typedef struct packed {
    logic [15:0] utf16_unit;
    logic        end_of_text;
  } unit_t;

  // Output transaction payload.
  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       last_of_run;
    logic       invalid_unit;
  } byte_t;

  // Bytes of one encoded code point, first byte in slot 0.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } enc_t;

  // One queue entry: all bytes caused by one accepted unit, slot 0 first.
  typedef struct packed {
    logic [5:0][7:0] bytes;
    logic [5:0]      bad;
    logic [2:0]      count;
  } job_t;

  // Encode one code point (up to 21 bits) into UTF-8.
  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e.bytes = '0;
    if (cp < 21'h80) begin
      e.bytes[0] = cp[7:0];
      e.len      = 3'd1;
    end else if (cp < 21'h800) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.len      = 3'd2;
    end else if (cp < SUPP_BASE) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.len      = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.len      = 3'd4;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

### rtl/u16u8_front.sv
// Front part of the transcoder: accepts UTF-16 units, tracks a pending high
// surrogate and turns each unit into one queue job of encoded bytes.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_front
  import u16u8_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  allow_lone,
  input  wire logic  unit_valid,
  output logic       unit_stall,
  input  wire unit_t unit_data,
  input  wire logic  q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic       pending_valid;
  logic [9:0] pending_bits;

  logic        accept;
  logic        is_hi;
  logic        is_lo;
  logic        pair;
  logic        flush;
  logic        has_main;
  logic        main_bad;
  logic [20:0] main_cp;
  logic [15:0] flush_unit;
  logic [15:0] lone_cp;
  enc_t        flush_enc;
  enc_t        main_enc;

  assign unit_stall = q_full;
  assign accept     = unit_valid && !q_full;

  // Classify the unit and choose the code points it completes.
  always_comb begin
    is_hi      = (unit_data.utf16_unit >= HI_MIN) && (unit_data.utf16_unit <= HI_MAX);
    is_lo      = (unit_data.utf16_unit >= LO_MIN) && (unit_data.utf16_unit <= LO_MAX);
    pair       = pending_valid && is_lo;
    flush      = pending_valid && !is_lo;
    flush_unit = HI_MIN | {6'd0, pending_bits};
    lone_cp    = allow_lone ? unit_data.utf16_unit : REPLACEMENT;
    if (pair) begin
      has_main = 1'b1;
      main_bad = 1'b0;
      main_cp  = 21'({pending_bits, unit_data.utf16_unit[9:0]}) + SUPP_BASE;
    end else if (is_hi) begin
      has_main = unit_data.end_of_text;
      main_bad = 1'b1;
      main_cp  = {5'd0, lone_cp};
    end else if (is_lo) begin
      has_main = 1'b1;
      main_bad = 1'b1;
      main_cp  = {5'd0, lone_cp};
    end else begin
      has_main = 1'b1;
      main_bad = 1'b0;
      main_cp  = {5'd0, unit_data.utf16_unit};
    end
    flush_enc = utf8_encode({5'd0, allow_lone ? flush_unit : REPLACEMENT});
    main_enc  = utf8_encode(main_cp);
  end

  // Pack the flushed surrogate (always three bytes) ahead of the main code point.
  always_comb begin
    q_job = '0;
    if (flush) begin
      q_job.bytes[0] = flush_enc.bytes[0];
      q_job.bytes[1] = flush_enc.bytes[1];
      q_job.bytes[2] = flush_enc.bytes[2];
      q_job.bytes[3] = main_enc.bytes[0];
      q_job.bytes[4] = main_enc.bytes[1];
      q_job.bytes[5] = main_enc.bytes[2];
      q_job.bad      = {{3{main_bad}}, 3'b111};
    end else begin
      q_job.bytes[0] = main_enc.bytes[0];
      q_job.bytes[1] = main_enc.bytes[1];
      q_job.bytes[2] = main_enc.bytes[2];
      q_job.bytes[3] = main_enc.bytes[3];
      q_job.bad      = {6{main_bad}};
    end
    q_job.count = (flush ? 3'd3 : 3'd0) + (has_main ? main_enc.len : 3'd0);
  end

  // A unit that completes no code point leaves no job behind.
  assign q_push = accept && (q_job.count != 3'd0);

  // Pending high surrogate state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
      pending_bits  <= '0;
    end else if (accept) begin
      pending_valid <= is_hi && !unit_data.end_of_text;
      pending_bits  <= unit_data.utf16_unit[9:0];
    end
  end

endmodule

`default_nettype wire

### rtl/u16u8_queue.sv
// Job queue between the front and back parts of the transcoder.
// Small register FIFO of job_t entries. Depends on u16u8_pkg.
`default_nettype none

module u16u8_queue
  import u16u8_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full       = (fill == CNT_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/u16u8_back.sv
// Back part of the transcoder: walks the bytes of the head job one per cycle
// (unless stalled) into a registered output channel. Depends on u16u8_pkg.
`default_nettype none

module u16u8_back
  import u16u8_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic head_valid,
  input  wire job_t head_job,
  output logic      pop,
  output logic      byte_valid,
  input  wire logic byte_stall,
  output byte_t     byte_data
);

  logic [2:0] idx;
  logic       load;
  logic       last;

  // The output register can take a new byte when empty or being drained.
  assign load = !byte_valid || !byte_stall;
  assign last = (idx == head_job.count - 3'd1);
  assign pop  = load && head_valid && last;

  // Byte index within the head job and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      byte_valid <= 1'b0;
    end else if (load) begin
      byte_valid <= head_valid;
      if (head_valid) begin
        idx <= last ? 3'd0 : idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      byte_data.utf8_byte    <= head_job.bytes[idx];
      byte_data.last_of_run  <= last;
      byte_data.invalid_unit <= head_job.bad[idx];
    end
  end

endmodule

`default_nettype wire

### rtl/utf16_to_utf8_transcoder_unit.sv
// UTF-16 to UTF-8 transcoder, top level. A unit is taken every cycle while the
// job queue has space; the back part emits one UTF-8 byte per cycle while the
// output is not stalled. A unit yields 0 to 6 bytes (1-3 for BMP text, 4 for a
// pair, 6 for a flushed surrogate plus a lone one).
// Synchronous active-high reset empties the queue, drops a pending surrogate
// and selects strict mode (lone surrogates become U+FFFD).
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
`default_nettype none

module utf16_to_utf8_transcoder_unit
  import u16u8_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // UTF-16 unit channel.
  input  wire logic        unit_valid,
  output logic             unit_stall,
  input  wire unit_t       unit_data,
  // UTF-8 byte channel.
  output logic             byte_valid,
  input  wire logic        byte_stall,
  output byte_t            byte_data
);

  logic allow_lone;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_head_valid;
  job_t q_push_job;
  job_t q_head_job;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ALLOW_LONE) ? {31'd0, allow_lone} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_lone <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ALLOW_LONE)) begin
      allow_lone <= pwdata[0];
    end
  end

  // Front, queue and back.
  u16u8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .allow_lone (allow_lone),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_data  (unit_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_push_job)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data)
  );

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the UTF-16 to UTF-8 transcoder: a queue-fed unit driver, a byte
// monitor that checks against an in-bench transcoding predictor, and APB setup.
// Depends on u16u8_pkg and utf16_to_utf8_transcoder_unit.

module tb_top;
  import u16u8_pkg::*;

  localparam logic [2:0] ALLOW_ADDR   = 3'(REG_ALLOW_LONE) * 3'd4;
  localparam logic [2:0] SPARE_ADDR   = 3'd4;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         HOLD_AT      = 60;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         TIMEOUT_NS   = 4_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        unit_valid = 1'b0;
  logic        unit_stall;
  unit_t       unit_data = '0;
  logic        byte_valid;
  logic        byte_stall = 1'b0;
  byte_t       byte_data;

  // Units waiting to be offered and UTF-8 bytes the transcoder still owes.
  unit_t pending_units[$];
  byte_t owed_bytes[$];

  // Predicted register and surrogate state.
  logic       allow_raw = 1'b0;
  logic       hi_waiting = 1'b0;
  logic [9:0] hi_bits = '0;

  int send_idle_pct = 25;
  int recv_stall_pct = 65;
  int units_accepted = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit hold_used = 1'b0;

  utf16_to_utf8_transcoder_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_data  (unit_data),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  // Append one owed byte; the end-of-run flag is set once the unit is done.
  task automatic owe_byte(input logic [7:0] value, input logic bad);
    byte_t b;
    b.utf8_byte    = value;
    b.last_of_run  = 1'b0;
    b.invalid_unit = bad;
    owed_bytes.push_back(b);
  endtask

  // UTF-8 encoding: lead byte carries the top bits, continuations six each.
  task automatic owe_code_point(input logic [20:0] cp, input logic bad);
    int         nbytes;
    int         k;
    logic [7:0] lead;
    logic [20:0] chunk;
    nbytes = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
    lead = (nbytes == 1) ? 8'h00 : (nbytes == 2) ? 8'hC0 : (nbytes == 3) ? 8'hE0 : 8'hF0;
    for (k = nbytes - 1; k >= 0; k--) begin
      chunk = cp >> (6 * k);
      if (k == nbytes - 1) begin
        owe_byte(lead | chunk[7:0], bad);
      end else begin
        owe_byte(8'h80 | {2'b00, chunk[5:0]}, bad);
      end
    end
  endtask

  // A lone surrogate is either passed through raw or replaced by U+FFFD.
  task automatic owe_lone(input logic [15:0] cu);
    owe_code_point(allow_raw ? {5'b0, cu} : {5'b0, REPLACEMENT}, 1'b1);
  endtask

  // Work out every byte that one accepted unit releases.
  task automatic transcode_unit(input unit_t u);
    logic  is_hi;
    logic  is_lo;
    int    start_size;
    byte_t tail;
    start_size = owed_bytes.size();
    is_hi = (u.utf16_unit >= HI_MIN) && (u.utf16_unit <= HI_MAX);
    is_lo = (u.utf16_unit >= LO_MIN) && (u.utf16_unit <= LO_MAX);
    if (hi_waiting && is_lo) begin
      owe_code_point({1'b0, hi_bits, 10'b0} + 21'(u.utf16_unit - LO_MIN) + SUPP_BASE, 1'b0);
      hi_waiting = 1'b0;
      hi_bits    = '0;
    end else begin
      // A held high surrogate that is not completed goes out first.
      if (hi_waiting) begin
        owe_lone(HI_MIN | {6'b0, hi_bits});
        hi_waiting = 1'b0;
        hi_bits    = '0;
      end
      if (is_hi) begin
        if (u.end_of_text) begin
          owe_lone(u.utf16_unit);
        end else begin
          hi_waiting = 1'b1;
          hi_bits    = u.utf16_unit[9:0];
        end
      end else if (is_lo) begin
        owe_lone(u.utf16_unit);
      end else begin
        owe_code_point({5'b0, u.utf16_unit}, 1'b0);
      end
    end
    if (owed_bytes.size() > start_size) begin
      tail = owed_bytes.pop_back();
      tail.last_of_run = 1'b1;
      owed_bytes.push_back(tail);
    end
  endtask

  // Unit driver: predicts on each transaction, then offers the next unit.
  always @(posedge clk) begin
    if (rst) begin
      unit_valid <= 1'b0;
    end else begin
      if (unit_valid && !unit_stall) begin
        transcode_unit(unit_data);
        units_accepted <= units_accepted + 1;
      end
      if (!unit_valid || !unit_stall) begin
        if (pending_units.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          unit_valid <= 1'b1;
          unit_data  <= pending_units.pop_front();
        end else begin
          unit_valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off so that the queue fills and the input stalls.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && units_accepted == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Byte monitor: each transaction is checked against the oldest owed byte.
  always @(posedge clk) begin : byte_monitor
    byte_t want;
    if (rst) begin
      byte_stall <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        if (owed_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected byte %h last %b invalid %b", byte_data.utf8_byte,
                     byte_data.last_of_run, byte_data.invalid_unit);
          end
        end else begin
          want = owed_bytes.pop_front();
          if (byte_data.utf8_byte !== want.utf8_byte ||
              byte_data.last_of_run !== want.last_of_run ||
              byte_data.invalid_unit !== want.invalid_unit) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("byte mismatch: expected %h last %b invalid %b, got %h last %b invalid %b",
                       want.utf8_byte, want.last_of_run, want.invalid_unit,
                       byte_data.utf8_byte, byte_data.last_of_run, byte_data.invalid_unit);
            end
          end
        end
      end
      byte_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ALLOW_ADDR) allow_raw = data[0];
    @(negedge clk);
  endtask

  task automatic queue_unit(input logic [15:0] cu, input logic eot);
    unit_t u;
    u.utf16_unit  = cu;
    u.end_of_text = eot;
    pending_units.push_back(u);
  endtask

  // Random text: mostly well-formed code units and pairs, some broken input.
  task automatic queue_random_text(input int count);
    int          pick;
    logic [15:0] cu;
    logic        eot;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      eot  = ($urandom_range(0, 9) == 0);
      if (pick < 25) begin
        cu = 16'($urandom_range(16'h0000, 16'h007F));
      end else if (pick < 40) begin
        cu = 16'($urandom_range(16'h0080, 16'h07FF));
      end else if (pick < 55) begin
        cu = $urandom_range(0, 1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                  : 16'($urandom_range(16'hE000, 16'hFFFF));
      end else if (pick < 75) begin
        queue_unit(16'($urandom_range(HI_MIN, HI_MAX)), 1'b0);
        cu = 16'($urandom_range(LO_MIN, LO_MAX));
      end else if (pick < 83) begin
        cu = 16'($urandom_range(HI_MIN, HI_MAX));
      end else if (pick < 90) begin
        cu = 16'($urandom_range(LO_MIN, LO_MAX));
      end else begin
        cu = 16'($urandom());
      end
      queue_unit(cu, eot);
    end
  endtask

  // Wait until every unit is taken and every owed byte has arrived.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_units.size() != 0 || unit_valid || owed_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Strict mode: encoding length boundaries, pairs and lone surrogates.
    write_reg(ALLOW_ADDR, 32'd0);
    queue_unit(16'h0000, 1'b0);
    queue_unit(16'h007F, 1'b0);
    queue_unit(16'h0080, 1'b0);
    queue_unit(16'h07FF, 1'b0);
    queue_unit(16'h0800, 1'b0);
    queue_unit(16'hFFFF, 1'b1);
    queue_unit(16'hD800, 1'b0);
    queue_unit(16'hDC00, 1'b0);
    // Pair completed by a unit that also ends the text.
    queue_unit(16'hDBFF, 1'b0);
    queue_unit(16'hDFFF, 1'b1);
    queue_unit(16'hDC00, 1'b0);
    // Held high surrogate flushed by a plain unit, then by another high one.
    queue_unit(16'hD800, 1'b0);
    queue_unit(16'h0041, 1'b0);
    queue_unit(16'hDBFF, 1'b0);
    queue_unit(16'hDBFF, 1'b0);
    // Flush plus a high surrogate at end of text gives the longest run.
    queue_unit(16'hD800, 1'b1);
    queue_unit(16'hDABC, 1'b1);
    queue_unit(16'hFFFD, 1'b0);
    wait_quiet();

    // Permissive mode; a write to the unused register must change nothing.
    write_reg(ALLOW_ADDR, 32'hFFFF_FFFF);
    write_reg(SPARE_ADDR, 32'd0);
    queue_unit(16'hDC00, 1'b0);
    queue_unit(16'hDFFF, 1'b1);
    queue_unit(16'hD955, 1'b0);
    queue_unit(16'hDBFF, 1'b1);
    queue_unit(16'hDABC, 1'b0);
    queue_unit(16'hE000, 1'b1);
    wait_quiet();

    // Random phases with changing idle patterns.
    write_reg(ALLOW_ADDR, 32'd0);
    queue_random_text(110);
    wait_quiet();

    send_idle_pct  = 65;
    recv_stall_pct = 25;
    write_reg(ALLOW_ADDR, 32'd1);
    queue_random_text(110);
    wait_quiet();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(ALLOW_ADDR, 32'($urandom_range(0, 1)));
    queue_random_text(110);
    wait_quiet();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/u16u8_pkg.sv
rtl/u16u8_front.sv
rtl/u16u8_queue.sv
rtl/u16u8_back.sv
rtl/utf16_to_utf8_transcoder_unit.sv
tb/sv/tb_top.sv
